>>> src/ppm_pkg.sv
// Package for the pointer position mapper: widths, command codes, register
// indexes and the lane control struct. No dependencies.
package ppm_pkg;
	localparam int FRAC_BITS = 8;
	localparam int ONE_F = 1 << FRAC_BITS;
	localparam int POS_W = 12 + FRAC_BITS;          // fine position width
	localparam int VAL_W = 21;                      // frame value width
	localparam int NUM_W = 36;                      // dividend magnitude width
	localparam int DEN_W = 12;                      // divisor width
	localparam int CNT_W = 6;
	localparam int VIEW_W = 20;

	localparam logic [1:0] CMD_SET = 2'd0;
	localparam logic [1:0] CMD_ABS = 2'd1;
	localparam logic [1:0] CMD_REL = 2'd2;
	localparam logic [1:0] CMD_LEAVE = 2'd3;

	localparam logic [2:0] REG_SPAN_X = 3'd0;
	localparam logic [2:0] REG_SPAN_Y = 3'd1;
	localparam logic [2:0] REG_MARGIN = 3'd2;
	localparam logic [2:0] REG_LO_X = 3'd3;
	localparam logic [2:0] REG_LO_Y = 3'd4;
	localparam logic [2:0] REG_HI_X = 3'd5;
	localparam logic [2:0] REG_HI_Y = 3'd6;

	// normalized bounds of one axis
	typedef struct packed {
		logic [11:0] lo;
		logic [11:0] hi;
		logic [11:0] span;
		logic [10:0] margin;
	} axis_t;

	// sequencer to lane control
	typedef struct packed {
		logic       start;   // first division launch for the taken beat
		logic [1:0] cmd;
		logic       div2;    // launch view division
	} lane_ctl_t;

	typedef struct packed {
		logic busy;
		logic out_side;      // absolute point outside this axis
	} lane_sts_t;
endpackage

>>> src/ppm_div.sv
// Restoring serial divider, one quotient bit a cycle.
// Depends on ppm_pkg.
module ppm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppm_pkg::NUM_W-1:0]     num,
	input  logic [ppm_pkg::DEN_W-1:0]     den,
	output logic                          busy,
	output logic [ppm_pkg::NUM_W-1:0]     quo
);
	logic [ppm_pkg::NUM_W-1:0] q_q;
	logic [ppm_pkg::DEN_W:0]   rem_q;
	logic [ppm_pkg::DEN_W-1:0] den_q;
	logic [ppm_pkg::CNT_W-1:0] cnt_q;
	logic [ppm_pkg::DEN_W+1:0] trial;

	assign trial = {rem_q, q_q[ppm_pkg::NUM_W-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ppm_pkg::CNT_W'(ppm_pkg::NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[ppm_pkg::DEN_W+1]) begin
				rem_q <= trial[ppm_pkg::DEN_W:0];
				q_q <= {q_q[ppm_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[ppm_pkg::DEN_W-1:0], q_q[ppm_pkg::NUM_W-1]};
				q_q <= {q_q[ppm_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = q_q;
endmodule

>>> src/ppm_lane.sv
// One axis lane: clamp, command update, leave pull, view scaling.
// Depends on ppm_pkg and ppm_div.
module ppm_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ppm_pkg::POS_W-1:0]     pos_reset,
	input  ppm_pkg::axis_t                ax,
	input  ppm_pkg::lane_ctl_t            ctl,
	input  logic [11:0]                   set_pos,
	input  logic signed [ppm_pkg::VAL_W-1:0] val,
	input  logic                          phase2,   // div result is the view
	input  logic                          fin1,     // first division done
	input  logic                          eff_leave,
	output ppm_pkg::lane_sts_t            sts,
	output logic [11:0]                   cursor,
	output logic [ppm_pkg::VIEW_W-1:0]    view
);
	localparam int PW = ppm_pkg::POS_W;
	localparam int FB = ppm_pkg::FRAC_BITS;

	logic [PW-1:0] pos_q;
	logic [PW-1:0] lo_f, hi_f, pin;
	logic [11:0] range;
	logic neg_q;
	logic div_start;
	logic div_busy, out_side;
	logic [ppm_pkg::NUM_W-1:0] div_num, quo;
	logic [ppm_pkg::DEN_W-1:0] div_den;
	logic [ppm_pkg::VAL_W-1:0] mag;
	logic [PW:0] qsat;
	logic signed [PW+2:0] nxt;
	logic [12:0] rnd;
	logic [PW-1:0] pfin;
	logic [12:0] top;

	assign lo_f = {ax.lo, FB'(0)};
	assign hi_f = {ax.hi, FB'(0)};
	assign range = ax.hi - ax.lo;
	assign pin = (pos_q < lo_f) ? lo_f : (pos_q > hi_f) ? hi_f : pos_q;
	assign mag = val[ppm_pkg::VAL_W-1] ? ppm_pkg::VAL_W'(-val) : val;
	assign out_side = val[ppm_pkg::VAL_W-1] ||
		(mag >= ppm_pkg::VAL_W'({ax.span, FB'(0)}));
	assign sts = '{busy: div_busy, out_side: out_side};

	// first division: |v|*range/span; second: (p-lo)*span/range
	always_comb begin
		div_start = 1'b0;
		div_num = ppm_pkg::NUM_W'(mag) * ppm_pkg::NUM_W'(range);
		div_den = ax.span;
		if (ctl.start) begin
			div_start = 1'b1;
		end else if (ctl.div2) begin
			div_start = 1'b1;
			div_num = ppm_pkg::NUM_W'(pos_q - lo_f) * ppm_pkg::NUM_W'(ax.span);
			div_den = range;
		end
	end

	ppm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(quo)
	);

	// first result applied to the clamped position
	always_comb begin
		// a relative step this large lands past a bound anyway
		qsat = (quo > ppm_pkg::NUM_W'({(PW+1){1'b1}})) ? '1 : quo[PW:0];
		rnd = 13'((pin + PW'(1 << (FB-1))) >> FB);
		nxt = (PW+3)'(pin);
		unique case (ctl.cmd)
			ppm_pkg::CMD_SET: nxt = (PW+3)'({set_pos, FB'(0)});
			ppm_pkg::CMD_ABS: begin
				if (mag < ppm_pkg::VAL_W'({ax.margin, FB'(0)}))
					nxt = (PW+3)'(lo_f);
				else if (mag >= ppm_pkg::VAL_W'({ax.span - 12'(ax.margin), FB'(0)}))
					nxt = (PW+3)'(hi_f);
				else
					nxt = (PW+3)'(lo_f) + (PW+3)'(quo);
			end
			ppm_pkg::CMD_REL: nxt = neg_q ? (PW+3)'(pin) - (PW+3)'(qsat) :
				(PW+3)'(pin) + (PW+3)'(qsat);
			default: nxt = (PW+3)'(pin);
		endcase
		if (eff_leave) begin
			nxt = (PW+3)'(pin);
			if (rnd <= {1'b0, ax.lo}) nxt = (PW+3)'({ax.lo + 12'd1, FB'(0)});
			if (rnd >= {1'b0, ax.hi}) nxt = (PW+3)'({ax.hi - 12'd1, FB'(0)});
		end
		if (nxt < $signed((PW+3)'(lo_f))) pfin = lo_f;
		else if (nxt > $signed((PW+3)'(hi_f))) pfin = hi_f;
		else pfin = nxt[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= pos_reset;
		end else if (fin1) begin
			pos_q <= pfin;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) neg_q <= val[ppm_pkg::VAL_W-1];
	end

	assign cursor = 12'((pos_q + PW'(1 << (FB-1))) >> FB);
	assign top = {1'b0, ax.span} - 13'd1;
	assign view = (quo > ppm_pkg::NUM_W'({top, FB'(0)})) ?
		ppm_pkg::VIEW_W'({top, FB'(0)}) : quo[ppm_pkg::VIEW_W-1:0];

	`ifndef NO_ASSERTIONS
	a_pos_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fin1) |-> (pos_q >= lo_f || $changed(ax)) ) else $error("pos below lo");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !sts.busy) else $error("div restarted");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fin1 |-> !phase2) else $error("fin in view phase");
	`endif
endmodule

>>> src/pointer_position_mapper.sv
// Top level of the pointer position mapper: registers, sequencer, two lanes.
// Depends on ppm_pkg and ppm_lane.
//
// Usage:
//  - Input channel (valid/stall): one beat carries a command and its
//    coordinates. stall is high while an item is in work.
//  - Output channel (valid/stall): one result beat per item: rounded
//    cursor, in_frame flag and frame-space view position.
//  - Config channel (valid/ready): cfg_index selects a register, to be
//    written by the user only while idle; the block does not enforce this. ready is always high.
//  - Each axis has its own lane with a 36-bit serial divider. An item runs
//    two divisions: the scaling of the command value, then (after the new
//    position is stored) the view scaling. Each division has a launch state
//    (LAUNCH, LAUNCH2) before its divide state (DIV1, DIV2); the next beat is
//    taken only after the sequencer has returned to IDLE.
//  - The result sits in an output register; a new item is taken while it
//    waits, and the block holds its next result until the receiver lets
//    the old one go.
//  - Reset puts the pointer at the center of the 640x480 frame, inside.
module pointer_position_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [11:0] set_pos_x,
	input  logic [11:0] set_pos_y,
	input  logic signed [20:0] frame_val_x,
	input  logic signed [20:0] frame_val_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] cursor_x,
	output logic [11:0] cursor_y,
	output logic        in_frame,
	output logic [19:0] view_x,
	output logic [19:0] view_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	typedef enum logic [2:0] {IDLE, DIV1, DIV2, HOLD, LAUNCH, LAUNCH2} st_t;
	st_t st_q;

	logic [11:0] span_x_q, span_y_q, lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic [10:0] margin_q;
	logic [1:0] cmd_q;
	logic [11:0] set_x_q, set_y_q;
	logic signed [20:0] val_x_q, val_y_q;
	logic in_q;
	ppm_pkg::axis_t ax, ay;
	ppm_pkg::lane_ctl_t ctl;
	ppm_pkg::lane_sts_t sx, sy;
	logic eff_leave, fin1, go, take, load;
	logic [11:0] cur_x, cur_y;
	logic [19:0] vw_x, vw_y;

	function automatic ppm_pkg::axis_t mk_axis(input logic [11:0] lo,
		input logic [11:0] hi, input logic [11:0] span, input logic [10:0] m);
		ppm_pkg::axis_t a;
		a.hi = (hi == 12'd0) ? 12'd1 : hi;
		a.lo = (hi == 12'd0) ? 12'd0 : lo;
		if (a.lo >= a.hi) a.lo = a.hi - 12'd1;
		a.span = (span == 12'd0) ? 12'd1 : span;
		a.margin = ({1'b0, m, 1'b0} >= {1'b0, a.span}) ? 11'd0 : m;
		return a;
	endfunction

	assign ax = mk_axis(lo_x_q, hi_x_q, span_x_q, margin_q);
	assign ay = mk_axis(lo_y_q, hi_y_q, span_y_q, margin_q);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_x_q <= 12'd640; span_y_q <= 12'd480; margin_q <= '0;
			lo_x_q <= '0; lo_y_q <= '0; hi_x_q <= 12'd640; hi_y_q <= 12'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ppm_pkg::REG_SPAN_X: span_x_q <= cfg_data;
				ppm_pkg::REG_SPAN_Y: span_y_q <= cfg_data;
				ppm_pkg::REG_MARGIN: margin_q <= cfg_data[10:0];
				ppm_pkg::REG_LO_X:   lo_x_q <= cfg_data;
				ppm_pkg::REG_LO_Y:   lo_y_q <= cfg_data;
				ppm_pkg::REG_HI_X:   hi_x_q <= cfg_data;
				ppm_pkg::REG_HI_Y:   hi_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item registers: the lanes see the captured beat
	assign take = in_valid && !in_stall;
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= command; set_x_q <= set_pos_x; set_y_q <= set_pos_y;
			val_x_q <= frame_val_x; val_y_q <= frame_val_y;
		end
	end

	// absolute point outside the frame acts as leave
	assign eff_leave = (cmd_q == ppm_pkg::CMD_LEAVE) ||
		((cmd_q == ppm_pkg::CMD_ABS) && (sx.out_side || sy.out_side));
	assign go = (st_q == LAUNCH);
	assign fin1 = (st_q == DIV1) && !sx.busy && !sy.busy && !go;
	assign in_stall = (st_q != IDLE);

	// view division launches in LAUNCH2, the cycle after the new position is stored
	assign ctl = '{start: go, cmd: cmd_q, div2: (st_q == LAUNCH2)};

	ppm_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .pos_reset(ppm_pkg::POS_W'(320 * ppm_pkg::ONE_F)),
		.ax(ax), .ctl(ctl), .set_pos(set_x_q), .val(val_x_q), .phase2(st_q == DIV2),
		.fin1(fin1), .eff_leave(eff_leave), .sts(sx), .cursor(cur_x), .view(vw_x)
	);
	ppm_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .pos_reset(ppm_pkg::POS_W'(240 * ppm_pkg::ONE_F)),
		.ax(ay), .ctl(ctl), .set_pos(set_y_q), .val(val_y_q), .phase2(st_q == DIV2),
		.fin1(fin1), .eff_leave(eff_leave), .sts(sy), .cursor(cur_y), .view(vw_y)
	);

	// result register is free, or its beat leaves this cycle
	assign load = (st_q == HOLD) && (!out_valid || !out_stall);

	// sequencer and merged result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			out_valid <= 1'b0;
			in_q <= 1'b1;
		end else begin
			if (load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				IDLE:   if (take) st_q <= LAUNCH;
				LAUNCH: st_q <= DIV1;
				DIV1: if (fin1) begin
					st_q <= LAUNCH2;
					in_q <= !eff_leave;
				end
				LAUNCH2: st_q <= DIV2;
				DIV2: if (!sx.busy && !sy.busy) st_q <= HOLD;
				HOLD: if (load) begin
					st_q <= IDLE;
					cursor_x <= cur_x; cursor_y <= cur_y; in_frame <= in_q;
					view_x <= vw_x; view_y <= vw_y;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	`ifndef NO_ASSERTIONS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != IDLE) |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(cursor_x))) else $error("drop");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(sx.busy == sy.busy)) else $error("lanes out of step");
	`endif
endmodule

>>> bench/pointer_position_mapper_tb.sv
// Self-checking bench for pointer_position_mapper: directed and random beats
// across several register settings, checked against an in-bench predictor.
// Depends on ppm_pkg and the RTL of pointer_position_mapper.
`timescale 1ns / 100ps

module pointer_position_mapper_tb;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int MAX_GAP = 18;

	typedef struct {
		longint lo, hi, span, margin;
	} bounds_t;

	typedef struct {
		logic [11:0] cx, cy;
		logic        in_fr;
		logic [19:0] vx, vy;
	} cursor_beat_t;

	// Predicts each result from its input beat and compares beats in order.
	class cursor_scoreboard;
		longint span_x = 640, span_y = 480, margin = 0;
		longint lo_x = 0, lo_y = 0, hi_x = 640, hi_y = 480;
		longint pos_x = (640 * ppm_pkg::ONE_F) / 2, pos_y = (480 * ppm_pkg::ONE_F) / 2;
		bit     in_now = 1;
		cursor_beat_t awaiting[$];
		int     mismatches = 0;
		int     checked = 0;

		function void set_reg(logic [2:0] idx, logic [11:0] val);
			case (idx)
				ppm_pkg::REG_SPAN_X: span_x = val;
				ppm_pkg::REG_SPAN_Y: span_y = val;
				ppm_pkg::REG_MARGIN: margin = val[10:0];
				ppm_pkg::REG_LO_X:   lo_x = val;
				ppm_pkg::REG_LO_Y:   lo_y = val;
				ppm_pkg::REG_HI_X:   hi_x = val;
				ppm_pkg::REG_HI_Y:   hi_y = val;
				default: ;
			endcase
		endfunction

		function bounds_t fix_bounds(longint lo, longint hi, longint span);
			bounds_t b;
			if (hi == 0) begin
				hi = 1;
				lo = 0;
			end
			if (lo >= hi) lo = hi - 1;
			if (span == 0) span = 1;
			b.lo = lo; b.hi = hi; b.span = span; b.margin = margin;
			if (b.margin * 2 >= b.span) b.margin = 0;
			return b;
		endfunction

		function longint clamp(longint v, bounds_t b);
			if (v < b.lo * ppm_pkg::ONE_F) return b.lo * ppm_pkg::ONE_F;
			if (v > b.hi * ppm_pkg::ONE_F) return b.hi * ppm_pkg::ONE_F;
			return v;
		endfunction

		function longint rounded(longint v);
			return (v + ppm_pkg::ONE_F / 2) / ppm_pkg::ONE_F;
		endfunction

		// frame value to bounds units, truncated toward zero
		function longint to_bounds(longint v, bounds_t b);
			if (v < 0) return -(((-v) * (b.hi - b.lo)) / b.span);
			return (v * (b.hi - b.lo)) / b.span;
		endfunction

		function longint pull_off_edge(longint p, bounds_t b);
			longint r;
			r = rounded(p);
			if (r <= b.lo) p = (b.lo + 1) * ppm_pkg::ONE_F;
			if (r >= b.hi) p = (b.hi - 1) * ppm_pkg::ONE_F;
			return p;
		endfunction

		function longint map_abs(longint v, bounds_t b);
			if (v < b.margin * ppm_pkg::ONE_F) return b.lo * ppm_pkg::ONE_F;
			if (v >= (b.span - b.margin) * ppm_pkg::ONE_F) return b.hi * ppm_pkg::ONE_F;
			return b.lo * ppm_pkg::ONE_F + to_bounds(v, b);
		endfunction

		function logic [19:0] frame_pos(longint p, bounds_t b);
			longint v;
			v = ((p - b.lo * ppm_pkg::ONE_F) * b.span) / (b.hi - b.lo);
			if (v < 0) v = 0;
			if (v > (b.span - 1) * ppm_pkg::ONE_F) v = (b.span - 1) * ppm_pkg::ONE_F;
			return v[19:0];
		endfunction

		function void note_item(logic [1:0] cmd, logic [11:0] sx, logic [11:0] sy,
				logic signed [20:0] fx, logic signed [20:0] fy);
			bounds_t bx, by;
			longint vx, vy;
			logic [1:0] op;
			cursor_beat_t r;
			bx = fix_bounds(lo_x, hi_x, span_x);
			by = fix_bounds(lo_y, hi_y, span_y);
			vx = fx;
			vy = fy;
			op = cmd;
			pos_x = clamp(pos_x, bx);
			pos_y = clamp(pos_y, by);
			// absolute point off the frame behaves as leave
			if (op == ppm_pkg::CMD_ABS && (vx < 0 || vy < 0 ||
					vx >= bx.span * ppm_pkg::ONE_F || vy >= by.span * ppm_pkg::ONE_F))
				op = ppm_pkg::CMD_LEAVE;
			case (op)
				ppm_pkg::CMD_SET: begin
					pos_x = longint'(sx) * ppm_pkg::ONE_F;
					pos_y = longint'(sy) * ppm_pkg::ONE_F;
					in_now = 1;
				end
				ppm_pkg::CMD_ABS: begin
					pos_x = map_abs(vx, bx);
					pos_y = map_abs(vy, by);
					in_now = 1;
				end
				ppm_pkg::CMD_REL: begin
					pos_x += to_bounds(vx, bx);
					pos_y += to_bounds(vy, by);
					in_now = 1;
				end
				default: begin
					in_now = 0;
					pos_x = pull_off_edge(pos_x, bx);
					pos_y = pull_off_edge(pos_y, by);
				end
			endcase
			pos_x = clamp(pos_x, bx);
			pos_y = clamp(pos_y, by);
			r.cx = 12'(rounded(pos_x));
			r.cy = 12'(rounded(pos_y));
			r.in_fr = in_now;
			r.vx = frame_pos(pos_x, bx);
			r.vy = frame_pos(pos_y, by);
			awaiting.push_back(r);
		endfunction

		function void check_result(cursor_beat_t got);
			cursor_beat_t exp_r;
			if (awaiting.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result beat with nothing pending: %0d %0d %0d %0h %0h",
						got.cx, got.cy, got.in_fr, got.vx, got.vy);
				return;
			end
			exp_r = awaiting.pop_front();
			checked++;
			if (got.cx !== exp_r.cx || got.cy !== exp_r.cy || got.in_fr !== exp_r.in_fr ||
					got.vx !== exp_r.vx || got.vy !== exp_r.vy) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: beat %0d exp cur %0d,%0d in %0d view %0h,%0h",
						checked, exp_r.cx, exp_r.cy, exp_r.in_fr, exp_r.vx, exp_r.vy);
					$display("       got cur %0d,%0d in %0d view %0h,%0h",
						got.cx, got.cy, got.in_fr, got.vx, got.vy);
				end
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 1;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  command = ppm_pkg::CMD_SET;
	logic [11:0] set_pos_x = '0, set_pos_y = '0;
	logic signed [20:0] frame_val_x = '0, frame_val_y = '0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [11:0] cursor_x, cursor_y;
	logic        in_frame;
	logic [19:0] view_x, view_y;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = ppm_pkg::REG_SPAN_X;
	logic [11:0] cfg_data = '0;

	cursor_scoreboard sb = new();
	int  cycles = 0;
	bit  tx_idle = 1;     // sender gaps enabled
	bit  rx_idle = 1;     // receiver stalls enabled
	int  phases = 0;

	pointer_position_mapper DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.awaiting.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result beats
	always @(posedge clk) begin
		cursor_beat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.cx = cursor_x; got.cy = cursor_y; got.in_fr = in_frame;
			got.vx = view_x; got.vy = view_y;
			sb.check_result(got);
		end
	end

	// receiver: stall a random count per beat, then take it
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			@(negedge clk);
			out_stall = (n > 0);
			repeat (n) @(negedge clk);
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [11:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// one input beat; valid stays high across back-to-back beats
	task automatic send_item(logic [1:0] cmd, logic [11:0] sx, logic [11:0] sy,
			logic signed [20:0] fx, logic signed [20:0] fy);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		in_valid = 1;
		command = cmd;
		set_pos_x = sx;
		set_pos_y = sy;
		frame_val_x = fx;
		frame_val_y = fy;
		do @(posedge clk); while (in_stall);
		sb.note_item(cmd, sx, sy, fx, fy);
	endtask

	// sender holds off until every pending result has arrived
	task automatic wait_empty();
		@(negedge clk);
		in_valid = 0;
		while (sb.awaiting.size() != 0) @(negedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic setup(logic [11:0] sx, logic [11:0] sy, logic [10:0] mg,
			logic [11:0] lx, logic [11:0] ly, logic [11:0] hx, logic [11:0] hy);
		drain();
		cfg_write(ppm_pkg::REG_SPAN_X, sx);
		cfg_write(ppm_pkg::REG_SPAN_Y, sy);
		cfg_write(ppm_pkg::REG_MARGIN, {1'b0, mg});
		cfg_write(ppm_pkg::REG_LO_X, lx);
		cfg_write(ppm_pkg::REG_LO_Y, ly);
		cfg_write(ppm_pkg::REG_HI_X, hx);
		cfg_write(ppm_pkg::REG_HI_Y, hy);
		phases++;
	endtask

	// random beats; mostly well-formed frame points, some raw noise
	task automatic random_items(int count);
		logic [1:0] cmd;
		logic signed [20:0] fx, fy;
		int  pick;
		int  tx, ty;
		for (int i = 0; i < count; i++) begin
			cmd = 2'($urandom_range(0, 3));
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// around the current frame, up to half a pixel past each edge (margins included)
				tx = int'($urandom_range(0, int'(sb.span_x) * ppm_pkg::ONE_F + 255)) - 128;
				ty = int'($urandom_range(0, int'(sb.span_y) * ppm_pkg::ONE_F + 255)) - 128;
				fx = 21'(tx);
				fy = 21'(ty);
			end else if (pick < 8) begin
				// small deltas
				fx = 21'(int'($urandom_range(0, 8191)) - 4096);
				fy = 21'(int'($urandom_range(0, 8191)) - 4096);
			end else begin
				fx = 21'($urandom);
				fy = 21'($urandom);
			end
			send_item(cmd, 12'($urandom), 12'($urandom), fx, fy);
			if (i % 60 == 59) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end
		end
	endtask

	initial begin
		#1 arst_n = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// directed, reset settings: extremes, every command, edge cases
		send_item(ppm_pkg::CMD_SET, 12'd4095, 12'd4095, 21'sd0, 21'sd0);  // clamps
		send_item(ppm_pkg::CMD_LEAVE, 12'd0, 12'd0, 21'sd0, 21'sd0);      // off high bound
		send_item(ppm_pkg::CMD_SET, 12'd0, 12'd0, 21'sd0, 21'sd0);
		send_item(ppm_pkg::CMD_LEAVE, 12'd0, 12'd0, 21'sd0, 21'sd0);      // off low bound
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd0, 21'sd0);
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd163839, 21'sd122879); // last pixel
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd163840, 21'sd100);    // off right
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, -21'sd1, 21'sd100);        // off left
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd1000, 21'sh100000);   // off top
		send_item(ppm_pkg::CMD_REL, 12'd0, 12'd0, 21'sd1048575, 21'sd1048575); // overflow
		send_item(ppm_pkg::CMD_REL, 12'd0, 12'd0, 21'sh100000, 21'sh100000);
		send_item(ppm_pkg::CMD_REL, 12'd0, 12'd0, 21'sd129, -21'sd129);
		send_item(ppm_pkg::CMD_SET, 12'd320, 12'd240, 21'sd0, 21'sd0);
		send_item(ppm_pkg::CMD_LEAVE, 12'hFFF, 12'hFFF, 21'sd1048575, -21'sd1);

		// margin snapping and an unequal mapping
		setup(12'd100, 12'd50, 11'd10, 12'd20, 12'd30, 12'd220, 12'd35);
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd2559, 21'sd2560);   // in / at margin
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd23040, 21'sd10239); // far margin
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd12345, 21'sd6000);
		send_item(ppm_pkg::CMD_REL, 12'd0, 12'd0, -21'sd77, 21'sd333);

		// inverted bounds, large margin, zero high bound
		setup(12'd4095, 12'd1, 11'd2047, 12'd4094, 12'd4094, 12'd1, 12'd0);
		send_item(ppm_pkg::CMD_SET, 12'd0, 12'd4095, 21'sd0, 21'sd0);
		send_item(ppm_pkg::CMD_ABS, 12'd0, 12'd0, 21'sd1048575, 21'sd255);
		send_item(ppm_pkg::CMD_LEAVE, 12'd0, 12'd0, 21'sd0, 21'sd0);
		send_item(ppm_pkg::CMD_REL, 12'd0, 12'd0, 21'sd1000, -21'sd1000);

		// random phases over several settings
		setup(12'd640, 12'd480, 11'd0, 12'd0, 12'd0, 12'd640, 12'd480);
		random_items(200);
		setup(12'd4095, 12'd4095, 11'd0, 12'd0, 12'd0, 12'd4095, 12'd4095);
		random_items(150);
		// hold off until every pending result has arrived
		wait_empty();
		random_items(50);
		setup(12'd1, 12'd1, 11'd0, 12'd4094, 12'd0, 12'd4095, 12'd1);
		random_items(100);
		setup(12'd1920, 12'd1080, 11'd40, 12'd100, 12'd200, 12'd1380, 12'd920);
		random_items(200);
		setup(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
			11'($urandom_range(0, 2047)),
			12'($urandom_range(0, 2000)), 12'($urandom_range(0, 2000)),
			12'($urandom_range(2001, 4095)), 12'($urandom_range(2001, 4095)));
		random_items(200);

		drain();
		$display("Covered %0d register settings and %0d result beats, all four commands,",
			phases + 1, sb.checked);
		$display("margins, off-frame points, inverted bounds and relative overflow.");
		if (sb.mismatches == 0 && sb.awaiting.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.mismatches,
				sb.awaiting.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
